@@ rtl/core/aam_pkg.sv @@
// Shared types and constants of the array address mapper.
// Depends on nothing; used by aam_ctrl, array_address_mapper, aam_checker and the testbench.
package aam_pkg;

  localparam int WORD_W         = 32;
  localparam int KIND_W         = 2;
  localparam int ID_PORT_W      = 4;
  localparam int DIM_W          = 4;
  localparam int MAX_ARRAYS_DEF = 16;
  localparam int MAX_DIMS_DEF   = 10;

  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BOUND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REF    = 2'd2;

  // one entry per array id
  typedef struct packed {
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] size;
    logic [DIM_W-1:0]  dims;
    logic [WORD_W-1:0] origin;
  } desc_t;

  // one entry per (array id, dimension)
  typedef struct packed {
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
    logic [WORD_W-1:0] stride;
  } dim_t;

endpackage

@@ rtl/core/aam_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module aam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/aam_ctrl.sv @@
// Sequencer and datapath of the array address mapper: decode, stride walk,
// index multiply-accumulate and defined marks. Uses aam_pkg; drives two aam_ram.
module aam_ctrl import aam_pkg::*; #(
  parameter int MAX_ARRAYS = MAX_ARRAYS_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  localparam int ID_W   = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1,
  localparam int SLOTS  = MAX_ARRAYS * MAX_DIMS,
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ID_PORT_W-1:0] in_array_id,
  input  logic [WORD_W-1:0]    in_base_address,
  input  logic [WORD_W-1:0]    in_element_size,
  input  logic [DIM_W-1:0]     in_dim_count,
  input  logic [WORD_W-1:0]    in_lower_bound,
  input  logic [WORD_W-1:0]    in_upper_bound,
  input  logic [WORD_W-1:0]    in_index_value,
  output logic                 out_valid,
  output logic [ID_PORT_W-1:0] out_result_array_id,
  output logic [WORD_W-1:0]    out_element_address,
  output logic [ID_W-1:0]      desc_raddr,
  input  desc_t                desc_rdata,
  output logic                 desc_we,
  output logic [ID_W-1:0]      desc_waddr,
  output desc_t                desc_wdata,
  output logic [SLOT_W-1:0]    dim_raddr,
  input  dim_t                 dim_rdata,
  output logic                 dim_we,
  output logic [SLOT_W-1:0]    dim_waddr,
  output dim_t                 dim_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_BND, S_IDX, S_WRD, S_WLD, S_WACC, S_WFIN
  } state_t;

  state_t              state_r;
  logic [ID_W-1:0]     id_r;
  logic [WORD_W-1:0]   base_r;
  logic [WORD_W-1:0]   size_r;
  logic [DIM_W-1:0]    dims_r;
  logic [WORD_W-1:0]   low_r;
  logic [WORD_W-1:0]   high_r;
  logic [WORD_W-1:0]   index_r;
  logic [DIM_W-1:0]    pos_r;
  logic [DIM_W-1:0]    bnd_pos_r;
  logic [DIM_W-1:0]    idx_pos_r;
  logic [WORD_W-1:0]   sum_r;
  logic [WORD_W-1:0]   stride_r;
  logic [WORD_W-1:0]   origin_r;
  logic [DIM_W-1:0]    walk_j_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                defined_r [MAX_ARRAYS];
  logic                out_valid_r;
  logic [ID_PORT_W-1:0] out_id_r;
  logic [WORD_W-1:0]   out_addr_r;

  logic                accept;
  logic                id_ok;
  logic [ID_W-1:0]     id_in;
  logic [DIM_W-1:0]    bnd_eff;
  logic [DIM_W-1:0]    idx_eff;
  logic [DIM_W-1:0]    pos_sel;
  logic [SLOT_W-1:0]   slot_in;
  logic [DIM_W-1:0]    dims_clamp;
  logic [DIM_W-1:0]    pos_inc;
  logic [WORD_W-1:0]   sum_base;
  logic [WORD_W-1:0]   addr_new;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign id_ok   = (32'(in_array_id) < MAX_ARRAYS);
  assign id_in   = ID_W'(in_array_id);
  assign bnd_eff = (32'(bnd_pos_r) >= MAX_DIMS) ? '0 : bnd_pos_r;
  assign idx_eff = (32'(idx_pos_r) >= MAX_DIMS) ? '0 : idx_pos_r;
  assign pos_sel = (in_kind == KIND_BOUND) ? bnd_eff : idx_eff;
  assign slot_in = SLOT_W'(32'(id_in) * MAX_DIMS + 32'(pos_sel));

  assign dims_clamp = (in_dim_count == '0) ? DIM_W'(1) :
                      (32'(in_dim_count) > MAX_DIMS) ? DIM_W'(MAX_DIMS) : in_dim_count;

  assign pos_inc  = DIM_W'(pos_r + 1'b1);
  assign sum_base = (pos_r == '0) ? desc_rdata.origin : sum_r;
  assign addr_new = sum_base + index_r * dim_rdata.stride;

  assign desc_raddr = id_in;
  assign dim_raddr  = (state_r == S_IDLE) ? slot_in : slot_r;

  always_comb begin
    desc_we    = 1'b0;
    desc_waddr = id_r;
    desc_wdata = '{base: base_r, size: size_r, dims: dims_r, origin: origin_r};
    dim_we     = 1'b0;
    dim_waddr  = slot_r;
    dim_wdata  = '{low: low_r, high: high_r, stride: dim_rdata.stride};
    unique case (state_r)
      S_HDR: begin
        desc_we = 1'b1;
      end
      S_BND: begin
        dim_we = 1'b1;
      end
      S_WLD: begin
        dim_we    = 1'b1;
        dim_wdata = '{low: dim_rdata.low, high: dim_rdata.high, stride: stride_r};
      end
      S_WFIN: begin
        desc_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bnd_pos_r   <= '0;
      idx_pos_r   <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ARRAYS; i++) begin
        defined_r[i] <= 1'b0;
      end
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            id_r    <= id_in;
            base_r  <= in_base_address;
            size_r  <= in_element_size;
            dims_r  <= dims_clamp;
            low_r   <= in_lower_bound;
            high_r  <= in_upper_bound;
            index_r <= in_index_value;
            pos_r   <= pos_sel;
            slot_r  <= slot_in;
            if (id_ok) begin
              unique case (in_kind)
                KIND_HEADER: begin
                  defined_r[id_in] <= 1'b0;
                  bnd_pos_r        <= '0;
                  state_r          <= S_HDR;
                end
                KIND_BOUND: begin
                  state_r <= S_BND;
                end
                KIND_REF: begin
                  if (defined_r[id_in]) begin
                    state_r <= S_IDX;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_HDR: begin
          state_r <= S_IDLE;
        end
        S_BND: begin
          if (pos_inc >= desc_rdata.dims) begin
            bnd_pos_r <= '0;
            base_r    <= desc_rdata.base;
            size_r    <= desc_rdata.size;
            dims_r    <= desc_rdata.dims;
            origin_r  <= desc_rdata.base;
            stride_r  <= desc_rdata.size;
            walk_j_r  <= DIM_W'(desc_rdata.dims - 1'b1);
            slot_r    <= SLOT_W'(32'(id_r) * MAX_DIMS + 32'(desc_rdata.dims) - 1);
            state_r   <= S_WRD;
          end else begin
            bnd_pos_r <= pos_inc;
            state_r   <= S_IDLE;
          end
        end
        S_IDX: begin
          if (pos_inc >= desc_rdata.dims) begin
            out_valid_r <= 1'b1;
            out_id_r    <= ID_PORT_W'(id_r);
            out_addr_r  <= addr_new;
            idx_pos_r   <= '0;
            sum_r       <= '0;
          end else begin
            idx_pos_r <= pos_inc;
            sum_r     <= addr_new;
          end
          state_r <= S_IDLE;
        end
        S_WRD: begin
          state_r <= S_WLD;
        end
        S_WLD: begin
          low_r   <= dim_rdata.low;
          high_r  <= dim_rdata.high - dim_rdata.low + 1'b1;
          state_r <= S_WACC;
        end
        S_WACC: begin
          origin_r <= origin_r - stride_r * low_r;
          stride_r <= stride_r * high_r;
          if (walk_j_r == '0) begin
            state_r <= S_WFIN;
          end else begin
            walk_j_r <= walk_j_r - 1'b1;
            slot_r   <= slot_r - 1'b1;
            state_r  <= S_WRD;
          end
        end
        S_WFIN: begin
          defined_r[id_r] <= 1'b1;
          state_r         <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_array_id = out_id_r;
  assign out_element_address = out_addr_r;

  a_out_from_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_IDX))
    else $error("result strobe without an index step");

  a_idx_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(idx_pos_r) < MAX_DIMS)
    else $error("index position out of range");

  a_walk_defines: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WFIN) |=> defined_r[id_r])
    else $error("finished descriptor not marked defined");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    !((state_r == S_IDLE) && (dim_we || desc_we)))
    else $error("memory write while idle");

endmodule

@@ rtl/core/array_address_mapper.sv @@
// Top level of the row-major array address mapper: sequencer plus the
// descriptor and dimension memories. Uses aam_pkg, aam_ctrl and aam_ram.
//
// Usage: an item is taken when start is high and busy is low. Header items
// (kind 0) store base, element size and dimension count of one id. Bound
// items (kind 1) store one dimension's bounds each; the last one starts a
// backward walk that writes the strides and the origin. Reference items
// (kind 2) carry one index each; the last index of a defined id yields
// out_valid for one cycle with out_result_array_id and out_element_address.
// Each header or bound item, and each reference of a defined id, passes
// through its step state (S_HDR, S_BND or S_IDX) before the next accept;
// the index step is one multiply-accumulate on the stride read from the
// dimension memory. A completing bound runs the walk, which reads and
// rewrites one dimension entry at a time. A result strobe comes in the
// cycle after the index step and cannot be held off by the receiver.
// Reset clears the defined marks and positions; the memories are not
// cleared, and a bound item may read them for an id with no header.
module array_address_mapper import aam_pkg::*; #(
  parameter int MAX_ARRAYS = MAX_ARRAYS_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [KIND_W-1:0]           in_kind,
  input  logic [ID_PORT_W-1:0]        in_array_id,
  input  logic signed [WORD_W-1:0]    in_base_address,
  input  logic signed [WORD_W-1:0]    in_element_size,
  input  logic [DIM_W-1:0]            in_dim_count,
  input  logic signed [WORD_W-1:0]    in_lower_bound,
  input  logic signed [WORD_W-1:0]    in_upper_bound,
  input  logic signed [WORD_W-1:0]    in_index_value,
  output logic                        out_valid,
  output logic [ID_PORT_W-1:0]        out_result_array_id,
  output logic signed [WORD_W-1:0]    out_element_address
);

  localparam int ID_W   = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
  localparam int SLOTS  = MAX_ARRAYS * MAX_DIMS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [ID_W-1:0]   desc_raddr;
  logic [ID_W-1:0]   desc_waddr;
  logic              desc_we;
  desc_t             desc_rdata;
  desc_t             desc_wdata;
  logic [SLOT_W-1:0] dim_raddr;
  logic [SLOT_W-1:0] dim_waddr;
  logic              dim_we;
  dim_t              dim_rdata;
  dim_t              dim_wdata;
  logic [WORD_W-1:0] elem_addr;

  aam_ctrl #(
    .MAX_ARRAYS (MAX_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_array_id         (in_array_id),
    .in_base_address     (in_base_address),
    .in_element_size     (in_element_size),
    .in_dim_count        (in_dim_count),
    .in_lower_bound      (in_lower_bound),
    .in_upper_bound      (in_upper_bound),
    .in_index_value      (in_index_value),
    .out_valid           (out_valid),
    .out_result_array_id (out_result_array_id),
    .out_element_address (elem_addr),
    .desc_raddr          (desc_raddr),
    .desc_rdata          (desc_rdata),
    .desc_we             (desc_we),
    .desc_waddr          (desc_waddr),
    .desc_wdata          (desc_wdata),
    .dim_raddr           (dim_raddr),
    .dim_rdata           (dim_rdata),
    .dim_we              (dim_we),
    .dim_waddr           (dim_waddr),
    .dim_wdata           (dim_wdata)
  );

  aam_ram #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (MAX_ARRAYS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (desc_waddr),
    .wdata (desc_wdata),
    .raddr (desc_raddr),
    .rdata (desc_rdata)
  );

  aam_ram #(
    .WIDTH ($bits(dim_t)),
    .DEPTH (SLOTS)
  ) u_dim_ram (
    .clk   (clk),
    .we    (dim_we),
    .waddr (dim_waddr),
    .wdata (dim_wdata),
    .raddr (dim_raddr),
    .rdata (dim_rdata)
  );

  assign out_element_address = $signed(elem_addr);

endmodule

@@ dv/aam_checker.sv @@
// Checker for the array address mapper: watches the item and result channels,
// predicts each element address and compares it with what the block emits.
// Depends on aam_pkg for widths, descriptor types and item kinds.
module aam_checker import aam_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ID_PORT_W-1:0] in_array_id,
  input  logic [WORD_W-1:0]    in_base_address,
  input  logic [WORD_W-1:0]    in_element_size,
  input  logic [DIM_W-1:0]     in_dim_count,
  input  logic [WORD_W-1:0]    in_lower_bound,
  input  logic [WORD_W-1:0]    in_upper_bound,
  input  logic [WORD_W-1:0]    in_index_value,
  input  logic                 out_valid,
  input  logic [ID_PORT_W-1:0] out_result_array_id,
  input  logic [WORD_W-1:0]    out_element_address,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NA = MAX_ARRAYS_DEF;
  localparam int ND = MAX_DIMS_DEF;

  typedef struct packed {
    logic [ID_PORT_W-1:0] id;
    logic [WORD_W-1:0]    addr;
  } addr_rec_t;

  desc_t             desc_tab [NA];
  dim_t              dim_tab  [NA*ND];
  logic              defined_tab [NA];
  int unsigned       bound_at;
  int unsigned       index_at;
  logic [WORD_W-1:0] running_sum;
  addr_rec_t         due_addresses [$];
  int                mismatches = 0;

  task automatic map_item(input logic [KIND_W-1:0] kind, input logic [ID_PORT_W-1:0] id,
                          input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] size,
                          input logic [DIM_W-1:0] dcnt, input logic [WORD_W-1:0] lo,
                          input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] idx);
    int unsigned d;
    int unsigned at;
    int unsigned j;
    logic [WORD_W-1:0] ext;
    logic [WORD_W-1:0] org;
    addr_rec_t rec;
    if (int'(id) >= NA) return;
    case (kind)
      KIND_HEADER: begin
        d = 32'(dcnt);
        if (d == 0) d = 1;
        if (d > ND) d = ND;
        desc_tab[id].base = base;
        desc_tab[id].size = size;
        desc_tab[id].dims = d[DIM_W-1:0];
        defined_tab[id]   = 1'b0;
        bound_at          = 0;
      end
      KIND_BOUND: begin
        if (bound_at >= ND) bound_at = 0;
        at = id * ND;
        dim_tab[at+bound_at].low  = lo;
        dim_tab[at+bound_at].high = hi;
        bound_at++;
        if (bound_at >= desc_tab[id].dims) begin
          // descriptor complete: strides from the last dimension back, then origin
          bound_at = 0;
          d = 32'(desc_tab[id].dims);
          dim_tab[at+d-1].stride = desc_tab[id].size;
          for (j = d - 1; j > 0; j--) begin
            ext = dim_tab[at+j].high - dim_tab[at+j].low + 1;
            dim_tab[at+j-1].stride = dim_tab[at+j].stride * ext;
          end
          org = desc_tab[id].base;
          for (j = 0; j < d; j++) org -= dim_tab[at+j].stride * dim_tab[at+j].low;
          desc_tab[id].origin = org;
          defined_tab[id]     = 1'b1;
        end
      end
      KIND_REF: begin
        if (defined_tab[id]) begin
          if (index_at >= ND) index_at = 0;
          if (index_at == 0) running_sum = desc_tab[id].origin;
          running_sum += idx * dim_tab[id*ND+index_at].stride;
          index_at++;
          if (index_at >= desc_tab[id].dims) begin
            rec.id        = id;
            rec.addr      = running_sum;
            due_addresses = {due_addresses, rec};
            index_at      = 0;
            running_sum   = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    addr_rec_t want;
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) defined_tab[i] = 1'b0;
      bound_at    = 0;
      index_at    = 0;
      running_sum = '0;
      due_addresses.delete();
    end else begin
      if (out_valid) begin
        if (due_addresses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result id %0d addr %h", $realtime,
                     out_result_array_id, out_element_address);
        end else begin
          want = due_addresses.pop_front();
          if (out_result_array_id !== want.id || out_element_address !== want.addr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch id exp %0d got %0d, addr exp %h got %h", $realtime,
                       want.id, out_result_array_id, want.addr, out_element_address);
          end
        end
      end
      if (start && !busy)
        map_item(in_kind, in_array_id, in_base_address, in_element_size, in_dim_count,
                 in_lower_bound, in_upper_bound, in_index_value);
    end
    fail_count <= mismatches;
    pending    <= due_addresses.size();
  end

endmodule

@@ dv/tb_array_address_mapper.sv @@
// Testbench top for the array address mapper: clock, reset, item stimulus
// and verdict. Depends on aam_pkg, array_address_mapper and aam_checker.
module tb_array_address_mapper;
  import aam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NA             = MAX_ARRAYS_DEF;
  localparam int ND             = MAX_DIMS_DEF;
  localparam int ITEM_TARGET    = 1125;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [KIND_W-1:0]    in_kind;
  logic [ID_PORT_W-1:0] in_array_id;
  logic [WORD_W-1:0]    in_base_address;
  logic [WORD_W-1:0]    in_element_size;
  logic [DIM_W-1:0]     in_dim_count;
  logic [WORD_W-1:0]    in_lower_bound;
  logic [WORD_W-1:0]    in_upper_bound;
  logic [WORD_W-1:0]    in_index_value;
  logic                 out_valid;
  logic [ID_PORT_W-1:0] out_result_array_id;
  logic [WORD_W-1:0]    out_element_address;
  int                   fail_count;
  int                   pending;

  // what the stimulus must know to stay clear of never-written entries
  bit hdr_seen [NA];
  bit def_m    [NA];
  int dims_m   [NA];
  bit low_done [NA*ND];
  bit strd_done[NA*ND];
  int bpos_m;
  int ipos_m;
  int items_sent;
  int burst_left;
  int idle_cycles;

  array_address_mapper u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_array_id         (in_array_id),
    .in_base_address     (in_base_address),
    .in_element_size     (in_element_size),
    .in_dim_count        (in_dim_count),
    .in_lower_bound      (in_lower_bound),
    .in_upper_bound      (in_upper_bound),
    .in_index_value      (in_index_value),
    .out_valid           (out_valid),
    .out_result_array_id (out_result_array_id),
    .out_element_address (out_element_address)
  );

  aam_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_array_id         (in_array_id),
    .in_base_address     (in_base_address),
    .in_element_size     (in_element_size),
    .in_dim_count        (in_dim_count),
    .in_lower_bound      (in_lower_bound),
    .in_upper_bound      (in_upper_bound),
    .in_index_value      (in_index_value),
    .out_valid           (out_valid),
    .out_result_array_id (out_result_array_id),
    .out_element_address (out_element_address),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("array_address_mapper verification failed");
        $finish;
      end
    end
  end

  function automatic int clamp_dims(input logic [DIM_W-1:0] dcnt);
    if (dcnt == 0) return 1;
    if (dcnt > ND) return ND;
    return int'(dcnt);
  endfunction

  function automatic bit item_ok(input logic [KIND_W-1:0] kind, input int id);
    int p;
    bit ok;
    ok = 1;
    if (kind == KIND_BOUND) begin
      if (!hdr_seen[id]) begin
        ok = 0;
      end else begin
        p = (bpos_m >= ND) ? 0 : bpos_m;
        if (p + 1 >= dims_m[id])
          for (int j = 0; j < dims_m[id]; j++)
            if (!low_done[id*ND+j] && j != p) ok = 0;
      end
    end else if (kind == KIND_REF && def_m[id]) begin
      p = (ipos_m >= ND) ? 0 : ipos_m;
      if (!strd_done[id*ND+p]) ok = 0;
    end
    return ok;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input int id,
                           input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] size,
                           input logic [DIM_W-1:0] dcnt, input logic [WORD_W-1:0] lo,
                           input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] idx);
    int gap;
    int p;
    if (!item_ok(kind, id)) return;
    start           <= 1'b1;
    in_kind         <= kind;
    in_array_id     <= id[ID_PORT_W-1:0];
    in_base_address <= base;
    in_element_size <= size;
    in_dim_count    <= dcnt;
    in_lower_bound  <= lo;
    in_upper_bound  <= hi;
    in_index_value  <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind != KIND_UNUSED && !(kind == KIND_REF && !def_m[id])) items_sent++;
    case (kind)
      KIND_HEADER: begin
        hdr_seen[id] = 1;
        def_m[id]    = 0;
        dims_m[id]   = clamp_dims(dcnt);
        bpos_m       = 0;
      end
      KIND_BOUND: begin
        p = (bpos_m >= ND) ? 0 : bpos_m;
        low_done[id*ND+p] = 1;
        bpos_m = p + 1;
        if (bpos_m >= dims_m[id]) begin
          bpos_m = 0;
          for (int j = 0; j < dims_m[id]; j++) strd_done[id*ND+j] = 1;
          def_m[id] = 1;
        end
      end
      KIND_REF: begin
        if (def_m[id]) begin
          p = (ipos_m >= ND) ? 0 : ipos_m;
          ipos_m = (p + 1 >= dims_m[id]) ? 0 : p + 1;
        end
      end
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 13);
    end
    if (gap > 0) begin
      start           <= 1'b0;
      in_kind         <= KIND_W'($urandom);
      in_array_id     <= ID_PORT_W'($urandom);
      in_base_address <= $urandom;
      in_element_size <= $urandom;
      in_dim_count    <= DIM_W'($urandom);
      in_lower_bound  <= $urandom;
      in_upper_bound  <= $urandom;
      in_index_value  <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_header(input int id, input logic [WORD_W-1:0] base,
                             input logic [WORD_W-1:0] size, input logic [DIM_W-1:0] dcnt);
    send_item(KIND_HEADER, id, base, size, dcnt, $urandom, $urandom, $urandom);
  endtask

  task automatic send_bound(input int id, input logic [WORD_W-1:0] lo,
                            input logic [WORD_W-1:0] hi);
    send_item(KIND_BOUND, id, $urandom, $urandom, DIM_W'($urandom), lo, hi, $urandom);
  endtask

  task automatic send_index(input int id, input logic [WORD_W-1:0] idx);
    send_item(KIND_REF, id, $urandom, $urandom, DIM_W'($urandom), $urandom, $urandom, idx);
  endtask

  task automatic send_bounds(input int id, input int count);
    int lo;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 3))
        0: send_bound(id, $urandom, $urandom);
        1: begin
          lo = $urandom_range(0, 10) - 5;
          send_bound(id, lo, lo - $urandom_range(1, 4));
        end
        default: begin
          lo = $urandom_range(0, 10) - 5;
          send_bound(id, lo, lo + $urandom_range(0, 6));
        end
      endcase
    end
  endtask

  task automatic define_array(input int id);
    logic [DIM_W-1:0] dcnt;
    logic [WORD_W-1:0] size;
    if ($urandom_range(0, 9) == 0) dcnt = DIM_W'($urandom_range(0, 15));
    else dcnt = DIM_W'($urandom_range(1, 4));
    if ($urandom_range(0, 3) == 0) size = $urandom;
    else size = 1 << $urandom_range(0, 3);
    send_header(id, $urandom, size, dcnt);
    send_bounds(id, clamp_dims(dcnt));
  endtask

  task automatic reference_array(input int id, input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) send_index(id, $urandom);
      else send_index(id, $urandom_range(0, 16) - 4);
    end
  endtask

  function automatic int find_defined();
    int s;
    s = $urandom_range(0, NA - 1);
    for (int i = 0; i < NA; i++)
      if (def_m[(s + i) % NA]) return (s + i) % NA;
    return -1;
  endfunction

  initial begin
    int id;
    int sel;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_kind         <= '0;
    in_array_id     <= '0;
    in_base_address <= '0;
    in_element_size <= '0;
    in_dim_count    <= '0;
    in_lower_bound  <= '0;
    in_upper_bound  <= '0;
    in_index_value  <= '0;
    bpos_m     = 0;
    ipos_m     = 0;
    items_sent = 0;
    burst_left = 0;
    for (int i = 0; i < NA; i++) begin
      hdr_seen[i] = 0;
      def_m[i]    = 0;
      dims_m[i]   = 1;
    end
    for (int i = 0; i < NA * ND; i++) begin
      low_done[i]  = 0;
      strd_done[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unused kind, undefined id, zero and oversized dim counts, extremes
    send_item(KIND_UNUSED, 3, $urandom, $urandom, DIM_W'($urandom), $urandom, $urandom,
              $urandom);
    send_index(5, 32'h1);
    send_header(0, 32'h7fffffff, 32'h80000000, 4'd0);
    send_bound(0, 32'h80000000, 32'h7fffffff);
    send_index(0, 32'hffffffff);
    send_header(15, 32'h80000000, 32'h7fffffff, 4'd15);
    for (int k = 0; k < ND - 1; k++) send_bound(15, k - 2, k * 2 - 2);
    send_index(15, 32'h0);  // incomplete descriptor: ignored
    send_bound(15, 32'hfffffffe, 32'h1);
    for (int k = 0; k < ND; k++)
      send_index(15, (k == 0) ? 32'h80000000 : (k == 1) ? 32'h7fffffff : k - 3);

    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      id  = find_defined();
      if (id < 0 || sel < 15) begin
        define_array($urandom_range(0, NA - 1));
      end else if (sel < 70) begin
        repeat ($urandom_range(1, 3)) reference_array(id, dims_m[id]);
      end else if (sel < 78) begin
        // broken reference, then a full one
        reference_array(id, $urandom_range(1, ND));
        id = find_defined();
        if (id >= 0) reference_array(id, dims_m[id]);
      end else if (sel < 84) begin
        id = $urandom_range(0, NA - 1);
        if (hdr_seen[id]) send_bounds(id, dims_m[id]);
      end else if (sel < 88) begin
        send_header($urandom_range(0, NA - 1), $urandom, $urandom,
                    DIM_W'($urandom_range(0, 15)));
      end else if (sel < 93) begin
        send_index($urandom_range(0, NA - 1), $urandom);
      end else if (sel < 96) begin
        send_item(KIND_UNUSED, $urandom_range(0, NA - 1), $urandom, $urandom,
                  DIM_W'($urandom), $urandom, $urandom, $urandom);
      end else begin
        send_item(KIND_W'($urandom_range(0, 3)), $urandom_range(0, NA - 1), $urandom,
                  $urandom, DIM_W'($urandom), $urandom, $urandom, $urandom);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("array_address_mapper verification clean");
    end else begin
      $display("array_address_mapper verification failed");
    end
    $finish;
  end

endmodule
